@@ rtl/aescbc_pkg.sv @@
// Package: types, constants and AES round functions for the CBC block encryptor.
package aescbc_pkg;

  localparam int unsigned KeySlots = 15;
  localparam int unsigned KeyIdxW  = 4;
  localparam int unsigned RoundMin = 10;

  localparam logic [1:0] CfgRoundCount = 2'd0;
  localparam logic [1:0] CfgIvHigh     = 2'd1;
  localparam logic [1:0] CfgIvLow      = 2'd2;

  localparam logic FuncKeyWrite = 1'b0;
  localparam logic FuncEncrypt  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  key_index;
    logic        first_block;
    logic [63:0] word_high;
    logic [63:0] word_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StKeyRead,
    StWhiten,
    StRound,
    StOut
  } ctrl_state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic                 load_item;
    logic                 key_wr;
    logic                 key_rd;
    logic [KeyIdxW-1:0]   key_rd_idx;
    logic                 whiten;
    logic                 do_round;
    logic                 last_round;
    logic                 load_out;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic         func;
    logic         key_idx_ok;
    logic [3:0]   rounds;
  } dp_stat_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round without the key add; byte 0 sits at bits [127:120].
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[rr+4*c] = Sbox[b[rr+4*((c+rr)%4)]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

endpackage

@@ rtl/aes_cbc_block_encryptor.sv @@
// AES-CBC encryptor, one round per cycle: a data transaction runs a key read, whitening
// and the rounds (the round count held to 10..14) on the single shared round unit, with a
// registered read of the round key memory; the next item is accepted only once the previous
// one has finished, a key write included. The result sits in an output register, so the
// next block runs while it waits; the controller stalls only when a second ciphertext is
// done before the first has been taken.
module aes_cbc_block_encryptor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aescbc_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aescbc_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  aescbc_pkg::cfg_item_t cfg_data_i
);

  aescbc_pkg::dp_cmd_t  cmd;
  aescbc_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  aescbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  aescbc_datapath u_dp (
    .clk_i, .rst_ni, .in_data_i,
    .cfg_we_i(cfg_valid_i), .cfg_data_i,
    .cmd_i(cmd), .stat_o(stat), .out_data_o
  );

endmodule

@@ rtl/aescbc_datapath.sv @@
// Datapath: item register, round key memory, chain, state and round unit.
module aescbc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aescbc_pkg::in_item_t  in_data_i,
  input  logic                  cfg_we_i,
  input  aescbc_pkg::cfg_item_t cfg_data_i,
  input  aescbc_pkg::dp_cmd_t   cmd_i,
  output aescbc_pkg::dp_stat_t  stat_o,
  output aescbc_pkg::out_item_t out_data_o
);

  logic [127:0] key_mem [aescbc_pkg::KeySlots];
  logic [127:0] key_q;
  aescbc_pkg::in_item_t item_q;
  logic [127:0] state_q, state_d;
  logic [127:0] chain_q;
  logic [127:0] iv_q;
  logic [127:0] out_q;
  logic [3:0]   round_count_q;
  logic [3:0]   rounds;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'd10;
      iv_q          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_data_i.index)
        aescbc_pkg::CfgRoundCount: round_count_q <= cfg_data_i.data[3:0];
        aescbc_pkg::CfgIvHigh:     iv_q[127:64]  <= cfg_data_i.data;
        aescbc_pkg::CfgIvLow:      iv_q[63:0]    <= cfg_data_i.data;
        default: ;
      endcase
    end
  end

  // saturate the round count into the supported range
  always_comb begin
    rounds = round_count_q;
    if (round_count_q < 4'(aescbc_pkg::RoundMin)) rounds = 4'(aescbc_pkg::RoundMin);
    if (round_count_q > 4'(aescbc_pkg::KeySlots - 1)) rounds = 4'(aescbc_pkg::KeySlots - 1);
  end

  // capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
  end

  // round key memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) key_mem[item_q.key_index] <= {item_q.word_high, item_q.word_low};
    if (cmd_i.key_rd) key_q <= key_mem[cmd_i.key_rd_idx];
  end

  // cipher state
  always_comb begin
    state_d = state_q;
    if (cmd_i.whiten) begin
      state_d = {item_q.word_high, item_q.word_low} ^
                (item_q.first_block ? iv_q : chain_q) ^ key_q;
    end else if (cmd_i.do_round) begin
      state_d = aescbc_pkg::aes_round(state_q, cmd_i.last_round) ^ key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  // chain takes the ciphertext after the final round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (cmd_i.do_round && cmd_i.last_round) begin
      chain_q <= state_d;
    end
  end

  // output register, held until the result transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= state_d;
  end

  assign stat_o.func       = item_q.func;
  assign stat_o.key_idx_ok = item_q.key_index < 4'(aescbc_pkg::KeySlots);
  assign stat_o.rounds     = rounds;
  assign out_data_o.cipher_high = out_q[127:64];
  assign out_data_o.cipher_low  = out_q[63:0];

endmodule

@@ rtl/aescbc_ctrl.sv @@
// Controller: sequences key writes, whitening and rounds for each transaction.
module aescbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  aescbc_pkg::dp_stat_t stat_i,
  output aescbc_pkg::dp_cmd_t  cmd_o
);

  aescbc_pkg::ctrl_state_e state_q, state_d;
  logic [3:0] round_q, round_d;
  logic       out_full_q, out_full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= aescbc_pkg::StIdle;
      round_q    <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      round_q    <= round_d;
      out_full_q <= out_full_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = out_full_q;
    case (state_q)
      aescbc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = aescbc_pkg::StKeyRead;
        end
      end
      aescbc_pkg::StKeyRead: begin
        if (stat_i.func == aescbc_pkg::FuncKeyWrite) begin
          cmd_o.key_wr = stat_i.key_idx_ok;
          state_d = aescbc_pkg::StIdle;
        end else begin
          cmd_o.key_rd = 1'b1;
          cmd_o.key_rd_idx = '0;
          state_d = aescbc_pkg::StWhiten;
        end
      end
      aescbc_pkg::StWhiten: begin
        cmd_o.whiten = 1'b1;
        cmd_o.key_rd = 1'b1;
        cmd_o.key_rd_idx = 4'd1;
        round_d = 4'd1;
        state_d = aescbc_pkg::StRound;
      end
      aescbc_pkg::StRound: begin
        cmd_o.do_round = 1'b1;
        cmd_o.last_round = (round_q == stat_i.rounds);
        cmd_o.key_rd = 1'b1;
        cmd_o.key_rd_idx = round_q + 4'd1;
        round_d = round_q + 4'd1;
        if (round_q == stat_i.rounds) begin
          cmd_o.key_rd = 1'b0;
          // move the ciphertext to the output register when it is free
          if (!out_full_q || out_ready_i) begin
            cmd_o.load_out = 1'b1;
            state_d = aescbc_pkg::StIdle;
          end else begin
            state_d = aescbc_pkg::StOut;
          end
        end
      end
      aescbc_pkg::StOut: begin
        // hold the ciphertext until the previous result has left
        if (!out_full_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = aescbc_pkg::StIdle;
        end
      end
      default: state_d = aescbc_pkg::StIdle;
    endcase
    // output register occupancy
    out_full_d = out_full_q;
    if (out_full_q && out_ready_i) out_full_d = 1'b0;
    if (cmd_o.load_out) out_full_d = 1'b1;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aescbc_pkg::StRound) |-> (round_q >= 4'd1 && round_q <= stat_i.rounds))
    else $error("round counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.whiten |=> (state_q == aescbc_pkg::StRound))
    else $error("whitening not followed by rounds");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.do_round && cmd_o.last_round) |=> out_valid_o)
    else $error("final round not followed by result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before acceptance");

endmodule

@@ dv/aes_cbc_block_encryptor_tb.sv @@
// Testbench for the AES-CBC block encryptor: random and directed traffic, scoreboard check.
`timescale 1ns / 1ps

module aes_cbc_block_encryptor_tb;

  localparam logic [1:0] CfgNoReg   = 2'd3;
  localparam int         HoldCycles = 300;
  localparam int         StallLimit = 5000;
  localparam int         DrainWait  = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  aescbc_pkg::in_item_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  aescbc_pkg::out_item_t out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  aescbc_pkg::cfg_item_t cfg_data_i = '0;

  aes_cbc_block_encryptor DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: round keys, chain, registers
  logic [127:0] key_slot [aescbc_pkg::KeySlots];
  logic [127:0] chain_val = '0;
  logic [3:0]   rounds_reg = 4'd10;
  logic [63:0]  iv_hi = '0, iv_lo = '0;

  aescbc_pkg::in_item_t  pend_q [$];
  aescbc_pkg::out_item_t cipher_q [$];
  int        sent_cnt = 0, taken_cnt = 0;
  int        fail_cnt = 0, idle_cycles = 0;
  bit        sender_busy = 1'b0, receiver_busy = 1'b0;
  int        hold_req = 0, hold_seen = 0, hold_left = 0;

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // one cipher round before the key add; byte k lives at bits [127-8k -: 8]
  function automatic logic [127:0] cipher_round(input logic [127:0] s, input bit last);
    logic [7:0] sb [16];
    logic [7:0] m0, m1, m2, m3, mix;
    logic [127:0] res;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sb[r + 4*c] = aescbc_pkg::Sbox[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        m0 = sb[4*c]; m1 = sb[4*c+1]; m2 = sb[4*c+2]; m3 = sb[4*c+3];
        mix = m0 ^ m1 ^ m2 ^ m3;
        sb[4*c]   = m0 ^ mix ^ gf_dbl(m0 ^ m1);
        sb[4*c+1] = m1 ^ mix ^ gf_dbl(m1 ^ m2);
        sb[4*c+2] = m2 ^ mix ^ gf_dbl(m2 ^ m3);
        sb[4*c+3] = m3 ^ mix ^ gf_dbl(m3 ^ m0);
      end
    end
    for (int k = 0; k < 16; k++) res[127 - 8*k -: 8] = sb[k];
    return res;
  endfunction

  // encrypt one block in CBC mode and advance the chain
  function automatic logic [127:0] cbc_encrypt(input aescbc_pkg::in_item_t it);
    int nr;
    logic [127:0] st;
    nr = (rounds_reg < 4'd10) ? 10 :
         (rounds_reg > aescbc_pkg::KeySlots - 1) ? aescbc_pkg::KeySlots - 1 : rounds_reg;
    if (it.first_block) chain_val = {iv_hi, iv_lo};
    st = {it.word_high, it.word_low} ^ chain_val ^ key_slot[0];
    for (int j = 1; j < nr; j++) st = cipher_round(st, 1'b0) ^ key_slot[j];
    st = cipher_round(st, 1'b1) ^ key_slot[nr];
    chain_val = st;
    return st;
  endfunction

  // sample accepted input transactions and predict
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      taken_cnt++;
      if (in_data_i.func == aescbc_pkg::FuncKeyWrite) begin
        if (in_data_i.key_index < aescbc_pkg::KeySlots)
          key_slot[in_data_i.key_index] = {in_data_i.word_high, in_data_i.word_low};
      end else begin
        cipher_q.push_back(aescbc_pkg::out_item_t'(cbc_encrypt(in_data_i)));
      end
    end
  end

  // check result transactions against the oldest expected ciphertext
  always @(posedge clk_i) begin
    aescbc_pkg::out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: result expected none actual %h", $realtime, out_data_o);
      end else begin
        want = cipher_q.pop_front();
        if (out_data_o.cipher_high !== want.cipher_high) begin
          fail_cnt++;
          $display("%0t: cipher_high expected %h actual %h", $realtime,
                   want.cipher_high, out_data_o.cipher_high);
        end
        if (out_data_o.cipher_low !== want.cipher_low) begin
          fail_cnt++;
          $display("%0t: cipher_low expected %h actual %h", $realtime,
                   want.cipher_low, out_data_o.cipher_low);
        end
      end
    end
  end

  // drive input transactions from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && (sent_cnt == taken_cnt)) begin
      if (pend_q.size() > 0 && (sender_busy || $urandom_range(99) >= 34)) begin
        in_data_i  <= pend_q.pop_front();
        in_valid_i <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // drive output ready with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && (receiver_busy || $urandom_range(99) >= 34);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic aescbc_pkg::in_item_t make_item(input logic fn, input logic [3:0] idx,
                                                     input logic fb, input logic [63:0] hi,
                                                     input logic [63:0] lo);
    aescbc_pkg::in_item_t it;
    it.func = fn; it.key_index = idx; it.first_block = fb;
    it.word_high = hi; it.word_low = lo;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic wait_drained();
    while (pend_q.size() > 0 || sent_cnt != taken_cnt || cipher_q.size() > 0)
      @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_data_i  <= '{index: idx, data: val};
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      aescbc_pkg::CfgRoundCount: rounds_reg = val[3:0];
      aescbc_pkg::CfgIvHigh:     iv_hi = val;
      aescbc_pkg::CfgIvLow:      iv_lo = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // queue random messages, mostly well-formed chains with some key writes
  task automatic queue_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        pend_q.push_back(make_item(aescbc_pkg::FuncKeyWrite, 4'($urandom_range(15)),
                                   1'($urandom), rand64(), rand64()));
      else
        pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'($urandom),
                                   $urandom_range(5) == 0, rand64(), rand64()));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fill every key slot, chain from reset, extreme blocks
    pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'd0, 1'b0, 64'd0, 64'd0) );
    pend_q.delete();
    for (int k = 0; k < aescbc_pkg::KeySlots; k++)
      pend_q.push_back(make_item(aescbc_pkg::FuncKeyWrite, 4'(k), 1'b0,
                                 k == 0 ? '0 : k == 1 ? '1 : rand64(),
                                 k == 0 ? '0 : k == 1 ? '1 : rand64()));
    pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'd9, 1'b0, 64'd0, 64'd0));
    pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'd15, 1'b0, '1, '1));
    pend_q.push_back(make_item(aescbc_pkg::FuncKeyWrite, 4'd15, 1'b1, '1, '1));
    pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'd0, 1'b1, 64'h0123456789abcdef,
                               64'hfedcba9876543210));
    pend_q.push_back(make_item(aescbc_pkg::FuncEncrypt, 4'd0, 1'b0, '1, 64'd0));
    wait_drained();

    // long stretch with no idling on either side
    sender_busy = 1'b1; receiver_busy = 1'b1;
    queue_traffic(120);
    wait_drained();
    sender_busy = 1'b0; receiver_busy = 1'b0;

    write_reg(aescbc_pkg::CfgRoundCount, 64'd12);
    write_reg(aescbc_pkg::CfgIvHigh, rand64());
    write_reg(aescbc_pkg::CfgIvLow, rand64());
    // receiver holds off while the sender keeps offering
    hold_req++;
    sender_busy = 1'b1;
    queue_traffic(120);
    wait_drained();
    sender_busy = 1'b0;

    write_reg(aescbc_pkg::CfgRoundCount, 64'd14);
    write_reg(aescbc_pkg::CfgIvHigh, '1);
    write_reg(aescbc_pkg::CfgIvLow, '1);
    queue_traffic(120);
    wait_drained();

    write_reg(aescbc_pkg::CfgRoundCount, 64'd0);
    write_reg(aescbc_pkg::CfgIvHigh, 64'd0);
    write_reg(aescbc_pkg::CfgIvLow, 64'd0);
    write_reg(CfgNoReg, '1);
    queue_traffic(120);
    wait_drained();

    write_reg(aescbc_pkg::CfgRoundCount, '1);
    write_reg(aescbc_pkg::CfgIvLow, rand64());
    queue_traffic(120);
    wait_drained();

    write_reg(aescbc_pkg::CfgRoundCount, 64'd11);
    queue_traffic(60);
    wait_drained();
    write_reg(aescbc_pkg::CfgRoundCount, 64'd13);
    write_reg(aescbc_pkg::CfgIvHigh, rand64());
    queue_traffic(60);
    wait_drained();

    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aescbc_pkg.sv
rtl/aescbc_datapath.sv
rtl/aescbc_ctrl.sv
rtl/aes_cbc_block_encryptor.sv
dv/aes_cbc_block_encryptor_tb.sv
